/* hdl/bmpu_pkg.sv */
// ---------------------------------------------------------------------------
// bmpu_pkg
// Shared types and constants of the banked memory paging unit.
// ---------------------------------------------------------------------------
`default_nettype none

package bmpu_pkg;

   localparam int BYTE_BITS       = 8;
   localparam int BANK_BITS       = 7;
   localparam int BANK_BYTES      = 16384;
   localparam int OFFSET_BITS     = $clog2(BANK_BYTES);
   localparam int CPU_ADDR_BITS   = 16;
   localparam int NUM_PORTS       = 4;
   localparam int PORT_BITS       = $clog2(NUM_PORTS);
   localparam int REGION_BITS     = 21;
   localparam int CHIP_BITS       = 20;
   localparam int FUNC_BITS       = 2;
   localparam int PORT_IDX_BITS   = 8;
   localparam int COUNT_BITS      = 8;
   localparam int RAM_SEL_BIT     = 7;
   localparam int CSR_IDX_BITS    = 1;
   localparam int DIV_STEPS       = BANK_BITS;
   localparam int STEP_BITS       = $clog2(DIV_STEPS + 1);

   localparam int REQ_FIELD_BITS  = FUNC_BITS + PORT_IDX_BITS + BYTE_BITS + CPU_ADDR_BITS;
   localparam int REQ_DATA_BITS   = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS  = BYTE_BITS + 1 + REGION_BITS + 1 + CHIP_BITS;
   localparam int RSP_DATA_BITS   = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(128);

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_WRITE     = 2'd0,
      FUNC_READ      = 2'd1,
      FUNC_TRANSLATE = 2'd2,
      FUNC_NONE      = 2'd3
   } func_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_RAM_COUNT   = 1'b0,
      CSR_FLASH_COUNT = 1'b1
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_COMMIT
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic div_commit;
   } dp_cmd_type;

   typedef struct packed {
      logic item_write;
   } dp_status_type;

endpackage

`default_nettype wire

/* hdl/bmpu_ctrl.sv */
// ---------------------------------------------------------------------------
// bmpu_ctrl
// Sequencer: accepts words, runs the bank reduction, owns the result valid.
// ---------------------------------------------------------------------------
`default_nettype none

module bmpu_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   input  bmpu_pkg::dp_status_type status,
   output bmpu_pkg::dp_cmd_type    cmd
);
   import bmpu_pkg::*;

   ctrl_state_type       state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 valid_ff, valid_in;
   logic                 accept;

   assign req_tready = (state_ff == ST_IDLE) && (!valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (accept && status.item_write) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(DIV_STEPS - 1)) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd.load       = accept;
      cmd.div_step   = (state_ff == ST_DIVIDE);
      cmd.div_commit = (state_ff == ST_COMMIT);
   end

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/bmpu_dp.sv */
// ---------------------------------------------------------------------------
// bmpu_dp
// Paging registers, bank counts, bit-serial bank reduction, result register.
// ---------------------------------------------------------------------------
`default_nettype none

module bmpu_dp (
   input  wire                                          clock,
   input  wire                                          reset,
   input  wire                                          csr_we,
   input  wire  [bmpu_pkg::CSR_IDX_BITS-1:0]            csr_index,
   input  wire  [bmpu_pkg::COUNT_BITS-1:0]              csr_wdata,
   input  wire  [bmpu_pkg::REQ_DATA_BITS-1:0]           req_tdata,
   output logic [bmpu_pkg::RSP_DATA_BITS-1:0]           rsp_tdata,
   input  bmpu_pkg::dp_cmd_type                         cmd,
   output bmpu_pkg::dp_status_type                      status
);
   import bmpu_pkg::*;

   // request fields
   func_type                   func;
   logic [PORT_IDX_BITS-1:0]   port_index;
   logic [BYTE_BITS-1:0]       port_value;
   logic [CPU_ADDR_BITS-1:0]   cpu_address;

   assign func        = func_type'(req_tdata[FUNC_BITS-1:0]);
   assign port_index  = req_tdata[FUNC_BITS +: PORT_IDX_BITS];
   assign port_value  = req_tdata[FUNC_BITS+PORT_IDX_BITS +: BYTE_BITS];
   assign cpu_address = req_tdata[FUNC_BITS+PORT_IDX_BITS+BYTE_BITS +: CPU_ADDR_BITS];

   assign status.item_write = (func == FUNC_WRITE);

   logic [COUNT_BITS-1:0]  ram_count_ff;
   logic [COUNT_BITS-1:0]  flash_count_ff;
   logic [BYTE_BITS-1:0]   page_bytes_ff [NUM_PORTS];
   logic [BANK_BITS-1:0]   page_banks_ff [NUM_PORTS];

   logic [BANK_BITS-1:0]   div_num_ff, div_num_in;
   logic [COUNT_BITS-1:0]  div_rem_ff, div_rem_in;
   logic [COUNT_BITS-1:0]  div_den_ff;
   logic [PORT_BITS-1:0]   div_port_ff;
   logic [COUNT_BITS-1:0]  rem_shift;

   logic [PORT_BITS-1:0]   port;
   logic [PORT_BITS-1:0]   rd_idx;
   logic [BYTE_BITS-1:0]   sel_byte;
   logic [BANK_BITS-1:0]   sel_bank;
   logic [REGION_BITS-1:0] region;

   logic [BYTE_BITS-1:0]   read_data_in;
   logic                   is_ram_in;
   logic [REGION_BITS-1:0] region_offset_in;
   logic                   flash_chip_in;
   logic [CHIP_BITS-1:0]   chip_offset_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff;

   assign port   = port_index[PORT_BITS-1:0];
   assign rd_idx = (func == FUNC_READ) ? port
                 : cpu_address[OFFSET_BITS +: PORT_BITS];
   assign sel_byte = page_bytes_ff[rd_idx];
   assign sel_bank = page_banks_ff[rd_idx];
   assign region   = {sel_bank, cpu_address[OFFSET_BITS-1:0]};

   always_comb begin
      read_data_in     = '0;
      is_ram_in        = 1'b0;
      region_offset_in = '0;
      flash_chip_in    = 1'b0;
      chip_offset_in   = '0;
      case (func)
         FUNC_READ: begin
            read_data_in = sel_byte;
         end
         FUNC_TRANSLATE: begin
            is_ram_in        = sel_byte[RAM_SEL_BIT];
            region_offset_in = region;
            if (!sel_byte[RAM_SEL_BIT]) begin
               flash_chip_in  = region[REGION_BITS-1];
               chip_offset_in = region[CHIP_BITS-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   // restoring remainder, one quotient bit per step
   assign rem_shift = {div_rem_ff[COUNT_BITS-2:0], div_num_ff[BANK_BITS-1]};

   always_comb begin
      div_num_in = {div_num_ff[BANK_BITS-2:0], 1'b0};
      if (rem_shift >= div_den_ff) begin
         div_rem_in = rem_shift - div_den_ff;
      end else begin
         div_rem_in = rem_shift;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_count_ff   <= COUNT_RESET;
         flash_count_ff <= COUNT_RESET;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_RAM_COUNT:   ram_count_ff   <= csr_wdata;
            CSR_FLASH_COUNT: flash_count_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PORTS; i++) begin
            page_bytes_ff[i] <= '0;
            page_banks_ff[i] <= '0;
         end
      end else begin
         if (cmd.load && (func == FUNC_WRITE)) begin
            page_bytes_ff[port] <= port_value;
         end
         if (cmd.div_commit) begin
            page_banks_ff[div_port_ff] <= (div_den_ff == '0) ? '0
                                         : div_rem_ff[BANK_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         div_num_ff  <= port_value[BANK_BITS-1:0];
         div_rem_ff  <= '0;
         div_port_ff <= port;
         div_den_ff  <= port_value[RAM_SEL_BIT] ? ram_count_ff : flash_count_ff;
         rsp_data_ff <= RSP_DATA_BITS'({chip_offset_in, flash_chip_in, region_offset_in,
                                        is_ram_in, read_data_in});
      end else if (cmd.div_step) begin
         div_num_ff <= div_num_in;
         div_rem_ff <= div_rem_in;
      end
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

`default_nettype wire

/* hdl/banked_memory_paging_unit.sv */
// ---------------------------------------------------------------------------
// banked_memory_paging_unit
// Four 16K-window paging registers with RAM/flash bank translation.
// ---------------------------------------------------------------------------
// Request words on req_* carry a function: write a paging port, read it back,
// or translate a CPU address to region, region offset and flash chip/offset.
// Every request yields exactly one response word on rsp_*, registered, in the
// cycle after acceptance. Reads and translates are accepted every cycle while
// the response register is free or being emptied; req_tready follows
// rsp_tready combinationally while that register is full.
// A port write reduces its bank number modulo the selected region's bank
// count in a bit-serial remainder unit: after the accepting cycle the sequencer
// runs its divide steps and then a commit, during which req_tready is low;
// reads and translates leave the sequencer idle.
// Bank counts are written through csr_* (index 0 RAM, 1 flash); the user must
// write them only while idle, which the block does not enforce. Reset clears
// all paging ports to zero and both counts to 128. When the receiver stalls,
// the response is held and req_tready drops until the word is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module banked_memory_paging_unit (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_we,
   input  wire  [bmpu_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire  [bmpu_pkg::COUNT_BITS-1:0]     csr_wdata,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // func[1:0], port_index[9:2], port_value[17:10], cpu_address[33:18]
   input  wire  [bmpu_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // read_data[7:0], is_ram[8], region_offset[29:9], flash_chip[30],
   // chip_offset[50:31]
   output logic [bmpu_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);
   import bmpu_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   bmpu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bmpu_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

`default_nettype wire
